// ===== hw/rtl/jbp_pkg.sv =====
package jbp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int PREFILL_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFILL = 2'd1;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_BLOCK = 1'b1;

  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd41288;
  localparam logic [PREFILL_W-1:0] PREFILL_RESET = 11'd960;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_in;
  } jbp_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       underrun;
    logic                       last;
  } jbp_out_t;

endpackage

// ===== hw/rtl/audio_jitter_buffer_playout.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid / in_stall        | jbp_in_t: mode, sample_in
// out     | output    | out_valid / out_stall      | jbp_out_t: sample_out, underrun, last
// cfg     | input     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Each sample of a playing block passes a store read, a pass through the shared
// multiplier and the output register in turn; an underrun block skips the store
// and the multiplier. The input stalls until the last sample of a block is taken.
// Reset is synchronous and active low; the sample store is not cleared.
module audio_jitter_buffer_playout #(
  parameter int DEPTH = 1024,
  parameter int BLOCK = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  jbp_pkg::jbp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output jbp_pkg::jbp_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jbp_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import jbp_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > PREFILL_W) ? FILL_W : PREFILL_W;
  localparam int CNT_W  = (BLOCK > 1) ? $clog2(BLOCK) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic                     playing_r, playing_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic [PREFILL_W-1:0]     prefill_r, prefill_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     underrun_r, underrun_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     in_acc;
  logic                     out_acc;
  logic                     push;
  logic                     armed;
  logic                     cnt_last;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] scaled;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign push     = in_acc && (in_data.mode == MODE_PUSH);
  assign cnt_last = (cnt_r == CNT_W'(BLOCK - 1));
  assign armed    = playing_r ||
                    (CMP_W'(fill_r) >= CMP_W'(prefill_r));

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  assign out_data.sample_out = underrun_r ? '0 : scaled;
  assign out_data.underrun   = underrun_r;
  assign out_data.last       = cnt_last;

  jbp_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (push),
    .wr_addr  (wr_ptr_r),
    .wr_data  (in_data.sample_in),
    .rd_addr  (rd_ptr_r),
    .rd_data_r(rd_data)
  );

  jbp_mul u_mul (
    .clk     (clk),
    .en      (state_r == ST_MUL),
    .sample  (rd_data),
    .gain    (gain_r),
    .scaled_r(scaled)
  );

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    fill_nxt      = fill_r;
    playing_nxt   = playing_r;
    gain_nxt      = gain_r;
    prefill_nxt   = prefill_r;
    cnt_nxt       = cnt_r;
    underrun_nxt  = underrun_r;
    out_valid_nxt = out_valid_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN:    gain_nxt = cfg_data;
        REG_PREFILL: prefill_nxt = cfg_data[PREFILL_W-1:0];
        default:     ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (push) begin
          wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
          if (fill_r != FILL_W'(DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
        end else if (in_acc) begin
          cnt_nxt = '0;
          if (armed && (fill_r >= FILL_W'(BLOCK))) begin
            playing_nxt  = 1'b1;
            fill_nxt     = fill_r - FILL_W'(BLOCK);
            underrun_nxt = 1'b0;
            state_nxt    = ST_READ;
          end else begin
            playing_nxt   = 1'b0;
            underrun_nxt  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_OUT;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (!underrun_r) begin
            rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
          end
          if (cnt_last) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else if (!underrun_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
      playing_r   <= 1'b0;
      gain_r      <= GAIN_RESET;
      prefill_r   <= PREFILL_RESET;
      cnt_r       <= '0;
      underrun_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fill_r      <= fill_nxt;
      playing_r   <= playing_nxt;
      gain_r      <= gain_nxt;
      prefill_r   <= prefill_nxt;
      cnt_r       <= cnt_nxt;
      underrun_r  <= underrun_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/jbp_store.sv =====
module jbp_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [jbp_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [AW-1:0]                       rd_addr,
  output logic signed [jbp_pkg::SAMPLE_W-1:0] rd_data_r
);
  import jbp_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/jbp_mul.sv =====
module jbp_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [jbp_pkg::SAMPLE_W-1:0] sample,
  input  logic [jbp_pkg::GAIN_W-1:0]          gain,
  output logic signed [jbp_pkg::SAMPLE_W-1:0] scaled_r
);
  import jbp_pkg::*;

  logic signed [SAMPLE_W+GAIN_W:0] prod;

  // The arithmetic shift of the product rounds toward minus infinity.
  assign prod = sample * $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= prod[SAMPLE_W+GAIN_W-1:GAIN_W];
    end
  end

endmodule

// ===== sim/jbp_playout_checker.sv =====
module jbp_playout_checker #(
  parameter int DEPTH = 1024,
  parameter int BLOCK = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  jbp_pkg::jbp_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  jbp_pkg::jbp_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [jbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jbp_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import jbp_pkg::*;

  logic [SAMPLE_W-1:0]  ring [DEPTH];
  int                   wr_ptr;
  int                   rd_ptr;
  int                   fill;
  logic                 playing;
  logic [GAIN_W-1:0]    gain;
  logic [PREFILL_W-1:0] prefill;
  jbp_out_t             expected_samples [$];
  jbp_out_t             oldest;
  int                   mismatches = 0;

  function automatic logic signed [SAMPLE_W-1:0] scaled(input logic signed [SAMPLE_W-1:0] s,
                                                         input logic [GAIN_W-1:0] g);
    logic signed [SAMPLE_W+GAIN_W:0] prod;
    prod = s * $signed({1'b0, g});
    return prod[SAMPLE_W+GAIN_W-1:GAIN_W];
  endfunction

  function void apply_request(input jbp_in_t req);
    jbp_out_t r;
    int k;
    if (req.mode == MODE_PUSH) begin
      ring[wr_ptr] = req.sample_in;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (fill < DEPTH) fill++;
    end else begin
      if (fill >= int'(prefill)) playing = 1'b1;
      if (playing && fill >= BLOCK) begin
        for (k = 0; k < BLOCK; k++) begin
          r.sample_out = scaled(ring[rd_ptr], gain);
          r.underrun   = 1'b0;
          r.last       = (k == BLOCK - 1);
          expected_samples.push_back(r);
          rd_ptr = (rd_ptr + 1) % DEPTH;
        end
        fill -= BLOCK;
      end else begin
        playing = 1'b0;
        for (k = 0; k < BLOCK; k++) begin
          r.sample_out = '0;
          r.underrun   = 1'b1;
          r.last       = (k == BLOCK - 1);
          expected_samples.push_back(r);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr  = 0;
      rd_ptr  = 0;
      fill    = 0;
      playing = 1'b0;
      gain    = GAIN_RESET;
      prefill = PREFILL_RESET;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:    gain = cfg_data[GAIN_W-1:0];
          REG_PREFILL: prefill = cfg_data[PREFILL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_request(in_data);
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected output sample=%0d underrun=%b last=%b", $realtime,
                     out_data.sample_out, out_data.underrun, out_data.last);
        end else begin
          oldest = expected_samples.pop_front();
          if (out_data.sample_out !== oldest.sample_out || out_data.underrun !== oldest.underrun
              || out_data.last !== oldest.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected sample=%0d underrun=%b last=%b, got sample=%0d underrun=%b last=%b",
                       $realtime, oldest.sample_out, oldest.underrun, oldest.last,
                       out_data.sample_out, out_data.underrun, out_data.last);
          end
        end
      end
    end
    pending    <= expected_samples.size();
    fail_count <= mismatches;
  end

endmodule

// ===== sim/tb_audio_jitter_buffer_playout.sv =====
module tb_audio_jitter_buffer_playout;
  timeunit 1ns;
  timeprecision 1ps;

  import jbp_pkg::*;

  localparam int BLOCK = 64;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  jbp_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  jbp_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int gap_max = 0;
  int wait_max = 0;
  int hold_cycles = 0;
  int sent_items = 0;

  logic signed [SAMPLE_W-1:0] corner_vals [9] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1,
                                                  16'sd1, 16'sh5555, -16'sh5556, 16'sd32766,
                                                  -16'sd32767};

  audio_jitter_buffer_playout u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  jbp_playout_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  task automatic send_request(input logic mode, input logic [SAMPLE_W-1:0] s);
    jbp_in_t req;
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.mode      = mode;
    req.sample_in = s;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic push_samples(input int n);
    repeat (n) send_request(MODE_PUSH, SAMPLE_W'($urandom));
  endtask

  task automatic push_with_corners(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (i < 9) send_request(MODE_PUSH, corner_vals[i]);
      else send_request(MODE_PUSH, SAMPLE_W'($urandom));
    end
  endtask

  task automatic request_blocks(input int n);
    repeat (n) send_request(MODE_BLOCK, SAMPLE_W'($urandom));
  endtask

  // The input has to be quiet before any register write, so the sender drains everything first.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] g, input logic [CFG_DAT_W-1:0] p);
    write_reg(REG_GAIN, g);
    write_reg(REG_PREFILL, p);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int n;
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = $urandom_range(0, wait_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20_000_000;
    $display("audio_jitter_buffer_playout test failed");
    $finish;
  end

  initial begin
    logic [CFG_DAT_W-1:0] g;
    logic [CFG_DAT_W-1:0] p;
    int nseq;
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: an empty store and a short fill both give silence.
    request_blocks(1);
    push_with_corners(BLOCK);
    request_blocks(1);

    wait_idle();
    set_config(16'hFFFF, 16'd0);
    request_blocks(2);

    wait_idle();
    gap_max  = 4;
    wait_max = 4;
    set_config(16'd0, 16'd64);
    push_with_corners(BLOCK + 6);
    request_blocks(2);

    // The output is held off for a long stretch while block requests keep coming.
    wait_idle();
    gap_max  = 1;
    wait_max = 1;
    set_config(CFG_DAT_W'($urandom), 16'd64);
    push_samples(BLOCK + 2);
    gap_max     = 0;
    hold_cycles = 400;
    request_blocks(3);

    wait_idle();
    gap_max  = 2;
    wait_max = 0;
    set_config(CFG_DAT_W'($urandom), 16'hFFFF);
    push_samples(BLOCK);
    request_blocks(1);

    wait_idle();
    write_reg(REG_PREFILL, 16'd1025);
    write_reg(REG_SPARE_2, CFG_DAT_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
    request_blocks(1);

    wait_idle();
    set_config(CFG_DAT_W'($urandom), 16'd64);
    request_blocks(1);

    while (sent_items < 410) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: g = 16'h0000;
        1: g = 16'hFFFF;
        default: g = CFG_DAT_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: p = 16'd0;
        1: p = CFG_DAT_W'($urandom_range(1025, 2047));
        default: p = CFG_DAT_W'($urandom_range(1, 128));
      endcase
      gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 4;
      wait_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      set_config(g, p);
      nseq = $urandom_range(1, 2);
      repeat (nseq) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat (12) send_request(($urandom_range(0, 3) == 0) ? MODE_BLOCK : MODE_PUSH,
                                   SAMPLE_W'($urandom));
        end else begin
          n = $urandom_range(4, 40);
          push_samples(n);
          n = $urandom_range(1, 2);
          request_blocks(n);
        end
      end
    end

    wait_idle();
    repeat (3 * BLOCK + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("audio_jitter_buffer_playout test passed");
    end else begin
      $display("audio_jitter_buffer_playout test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/jbp_pkg.sv
hw/rtl/jbp_store.sv
hw/rtl/jbp_mul.sv
hw/rtl/audio_jitter_buffer_playout.sv
sim/jbp_playout_checker.sv
sim/tb_audio_jitter_buffer_playout.sv
